@@ rtl/core/sdsh_pkg.sv @@
`timescale 1ns / 1ps
package sdsh_pkg;

   localparam int SECTOR_BYTES   = 512;
   localparam int RESPONSE_POLLS = 10;
   localparam int RSP_DEPTH      = 4;
   localparam int REQ_DEPTH      = 2;

   localparam logic [1:0] OP_INIT = 2'd0;
   localparam logic [1:0] OP_READ = 2'd1;
   localparam logic [1:0] OP_BYTE = 2'd2;
   localparam logic [1:0] OP_TICK = 2'd3;

   localparam logic [1:0] KIND_TX     = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_ERROR     = 2'd1;
   localparam logic [1:0] ST_NOT_READY = 2'd2;
   localparam logic [1:0] ST_PARAM     = 2'd3;

   localparam logic [7:0] CMD_GO_IDLE  = 8'h40;
   localparam logic [7:0] CMD_OP_MMC   = 8'h41;
   localparam logic [7:0] CMD_IF_COND  = 8'h48;
   localparam logic [7:0] CMD_SET_BLEN = 8'h50;
   localparam logic [7:0] CMD_READ_ONE = 8'h51;
   localparam logic [7:0] CMD_APP      = 8'h77;
   localparam logic [7:0] CMD_READ_OCR = 8'h7A;
   localparam logic [7:0] ACMD_OP_SD   = 8'hE9;

   localparam logic [7:0] CRC_GO_IDLE = 8'h95;
   localparam logic [7:0] CRC_IF_COND = 8'h87;
   localparam logic [7:0] CRC_OTHER   = 8'h01;
   localparam logic [7:0] IDLE_BYTE   = 8'hFF;
   localparam logic [7:0] DATA_TOKEN  = 8'hFE;

   localparam logic [3:0] TYPE_MMC   = 4'd1;
   localparam logic [3:0] TYPE_SD1   = 4'd2;
   localparam logic [3:0] TYPE_SD2   = 4'd4;
   localparam logic [3:0] TYPE_BLOCK = 4'd8;

   localparam logic [2:0] REG_SLOW_DIV   = 3'd0;
   localparam logic [2:0] REG_SD_DIV     = 3'd1;
   localparam logic [2:0] REG_MMC_DIV    = 3'd2;
   localparam logic [2:0] REG_INIT_TO    = 3'd3;
   localparam logic [2:0] REG_READY_TO   = 3'd4;
   localparam logic [2:0] REG_TOKEN_TO   = 3'd5;
   localparam logic [2:0] REG_TOKEN_POLL = 3'd6;

   typedef enum logic [3:0] {
      PH_IDLE, PH_DUMMY, PH_RDY_FIRST, PH_RDY_POLL, PH_CMD_TX, PH_RESP,
      PH_OCR, PH_TOKEN, PH_DATA, PH_RELEASE
   } phase_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] sector;
      logic [8:0]  offset;
      logic [9:0]  count;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] tx_byte;
      logic       chip_select;
      logic [7:0] clock_divider;
      logic [7:0] data_byte;
      logic [1:0] status;
      logic [3:0] card_type;
      logic       initialized;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  slow_divider;
      logic [7:0]  sd_fast_divider;
      logic [7:0]  mmc_fast_divider;
      logic [15:0] init_timeout_ticks;
      logic [15:0] ready_timeout_ticks;
      logic [15:0] token_timeout_ticks;
      logic [15:0] token_wait_polls;
   } cfg_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } rsp_push_type;

endpackage

@@ rtl/core/sdsh_req_fifo.sv @@
`timescale 1ns / 1ps
module sdsh_req_fifo import sdsh_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type wr_data,
   output logic    full,
   output logic    valid,
   input  logic    take,
   output req_type rd_data
);
   req_type    mem [REQ_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_wr, do_rd;

   assign full    = (count_ff == 2'(REQ_DEPTH));
   assign valid   = (count_ff != 2'd0);
   assign rd_data = mem[rd_ptr_ff];
   assign do_wr   = push && !full;
   assign do_rd   = take && valid;

   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_wr) - 2'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

@@ rtl/core/sdsh_rsp_fifo.sv @@
`timescale 1ns / 1ps
module sdsh_rsp_fifo import sdsh_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  rsp_push_type wr,
   output logic         room2,
   output logic         empty,
   input  logic         pop,
   output rsp_type      rd_data
);
   rsp_type    mem [RSP_DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       do_rd;

   assign empty   = (count_ff == 3'd0);
   assign room2   = (count_ff <= 3'(RSP_DEPTH - 2));
   assign rd_data = mem[rd_ptr_ff];
   assign do_rd   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + wr.count;
      rd_ptr_in = rd_ptr_ff + 2'(do_rd);
      count_in  = count_ff + 3'(wr.count) - 3'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (wr.count != 2'd0) begin
         mem[wr_ptr_ff] <= wr.first;
      end
      if (wr.count == 2'd2) begin
         mem[wr_ptr_ff + 2'd1] <= wr.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(RSP_DEPTH))
      else $error("result queue count out of range");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (wr.count != 2'd0) |-> (4'(count_ff) + 4'(wr.count) <= 4'(RSP_DEPTH)))
      else $error("result queue overflow");
   a_held: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty)
      else $error("waiting result lost");
`endif
endmodule

@@ rtl/core/sdsh_seq.sv @@
`timescale 1ns / 1ps
module sdsh_seq import sdsh_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         item_valid,
   input  req_type      item,
   input  logic         room2,
   output logic         take,
   output rsp_push_type wr
);
   phase_type   phase_ff, phase_in;
   logic [3:0]  detected_ff, detected_in;
   logic [3:0]  work_ff, work_in;
   logic        init_done_ff, init_done_in;
   logic        selected_ff, selected_in;
   logic        high_speed_ff, high_speed_in;
   logic        prefix_ff, prefix_in;
   logic        is_read_ff, is_read_in;
   logic [15:0] long_ff, long_in;
   logic [15:0] ready_ff, ready_in;
   logic [15:0] bc_ff, bc_in;
   logic [3:0]  polls_ff, polls_in;
   logic [31:0] arg_ff, arg_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [9:0]  off_ff, off_in;
   logic [9:0]  cnt_ff, cnt_in;
   logic [1:0]  rstat_ff, rstat_in;
   logic [7:0]  ocr_ff [4];

   logic        go;
   logic        snd_go, fin_go, dat_go, st_go, beg_go, rel_go, fail_go, cd_go, fc_go;
   logic [7:0]  snd_byte, st_cmd, cd_res, fb_cmd, fb_byte;
   logic [31:0] st_arg, fb_arg;
   logic [1:0]  fin_stat, rel_stat;
   logic [15:0] bc_inc;
   logic [3:0]  poll_dec;
   logic        full_rd, lt, tok_wait;
   logic [10:0] rng;
   logic [7:0]  div_old, div_new;
   rsp_type     r_data, r_main;

   assign go   = item_valid && room2;
   assign take = go;
   assign lt   = (long_ff != 16'd0);
   assign full_rd = (off_ff == 10'd0) && (cnt_ff == 10'(SECTOR_BYTES));
   assign bc_inc  = bc_ff + 16'd1;
   assign poll_dec = polls_ff - 4'd1;
   assign rng = 11'(item.offset) + 11'(item.count);

   always_comb begin
      fb_cmd = prefix_ff ? CMD_APP : {1'b0, cmd_ff[6:0]};
      fb_arg = prefix_ff ? 32'd0 : arg_ff;
      case (bc_inc[2:0])
         3'd1:    fb_byte = fb_arg[31:24];
         3'd2:    fb_byte = fb_arg[23:16];
         3'd3:    fb_byte = fb_arg[15:8];
         3'd4:    fb_byte = fb_arg[7:0];
         default: fb_byte = (fb_cmd == CMD_GO_IDLE) ? CRC_GO_IDLE :
                            ((fb_cmd == CMD_IF_COND) ? CRC_IF_COND : CRC_OTHER);
      endcase
   end

   always_comb begin
      phase_in = phase_ff;   detected_in = detected_ff; work_in = work_ff;
      init_done_in = init_done_ff; selected_in = selected_ff;
      high_speed_in = high_speed_ff; prefix_in = prefix_ff; is_read_in = is_read_ff;
      long_in = long_ff; ready_in = ready_ff; bc_in = bc_ff; polls_in = polls_ff;
      arg_in = arg_ff; cmd_in = cmd_ff; off_in = off_ff; cnt_in = cnt_ff;
      rstat_in = rstat_ff;
      snd_go = 1'b0; fin_go = 1'b0; dat_go = 1'b0; st_go = 1'b0; beg_go = 1'b0;
      rel_go = 1'b0; fail_go = 1'b0; cd_go = 1'b0; fc_go = 1'b0;
      snd_byte = IDLE_BYTE; st_cmd = 8'd0; st_arg = 32'd0; cd_res = 8'd0;
      fin_stat = ST_OK; rel_stat = ST_OK; tok_wait = 1'b0;

      if (go) begin
         case (item.operation)
            OP_TICK: begin
               if (lt) long_in = long_ff - 16'd1;
               if (ready_ff != 16'd0) ready_in = ready_ff - 16'd1;
            end
            OP_INIT: begin
               if (phase_ff == PH_IDLE) begin
                  is_read_in = 1'b0; high_speed_in = 1'b0;
                  bc_in = 16'd10; phase_in = PH_DUMMY; snd_go = 1'b1;
               end
            end
            OP_READ: begin
               if (phase_ff == PH_IDLE) begin
                  if (item.count == 10'd0 || rng > 11'(SECTOR_BYTES)) begin
                     fin_go = 1'b1; fin_stat = ST_PARAM;
                  end else if (!init_done_ff) begin
                     fin_go = 1'b1; fin_stat = ST_NOT_READY;
                  end else begin
                     is_read_in = 1'b1;
                     off_in = 10'(item.offset);
                     cnt_in = item.count;
                     st_go = 1'b1; st_cmd = CMD_READ_ONE;
                     st_arg = (detected_ff & TYPE_BLOCK) != 4'd0 ? item.sector :
                              {item.sector[22:0], 9'd0};
                  end
               end
            end
            default: begin
               case (phase_ff)
                  PH_DUMMY: begin
                     bc_in = bc_ff - 16'd1;
                     if (bc_in != 16'd0) snd_go = 1'b1;
                     else begin
                        work_in = 4'd0; st_go = 1'b1; st_cmd = CMD_GO_IDLE;
                     end
                  end
                  PH_RDY_FIRST: begin
                     phase_in = PH_RDY_POLL; snd_go = 1'b1;
                  end
                  PH_RDY_POLL: begin
                     if (item.rx_byte == IDLE_BYTE) begin
                        phase_in = PH_CMD_TX; bc_in = 16'd0;
                        snd_go = 1'b1; snd_byte = fb_cmd;
                     end else if (ready_ff != 16'd0) snd_go = 1'b1;
                     else begin
                        cd_go = 1'b1; cd_res = IDLE_BYTE;
                     end
                  end
                  PH_CMD_TX: begin
                     bc_in = bc_inc;
                     if (bc_inc < 16'd6) begin
                        snd_go = 1'b1; snd_byte = fb_byte;
                     end else begin
                        phase_in = PH_RESP; polls_in = 4'(RESPONSE_POLLS); snd_go = 1'b1;
                     end
                  end
                  PH_RESP: begin
                     polls_in = poll_dec;
                     if (item.rx_byte[7] && poll_dec != 4'd0) snd_go = 1'b1;
                     else begin
                        cd_go = 1'b1; cd_res = item.rx_byte;
                     end
                  end
                  PH_OCR: begin
                     bc_in = bc_inc;
                     if (bc_inc < 16'd4) snd_go = 1'b1;
                     else if (cmd_ff == CMD_IF_COND) begin
                        if (ocr_ff[2] == 8'h01 && item.rx_byte == 8'hAA && lt) begin
                           st_go = 1'b1; st_cmd = ACMD_OP_SD; st_arg = 32'h4000_0000;
                        end else fail_go = 1'b1;
                     end else begin
                        work_in = ocr_ff[0][6] ? (TYPE_SD2 | TYPE_BLOCK) : TYPE_SD2;
                        rel_go = 1'b1;
                     end
                  end
                  PH_TOKEN: begin
                     if (item.rx_byte == IDLE_BYTE) begin
                        if (full_rd) tok_wait = lt;
                        else begin
                           bc_in = bc_ff - 16'd1;
                           tok_wait = (bc_in != 16'd0);
                        end
                     end
                     if (tok_wait) snd_go = 1'b1;
                     else if (item.rx_byte == DATA_TOKEN) begin
                        bc_in = 16'(SECTOR_BYTES + 2) - 16'(off_ff) - 16'(cnt_ff);
                        phase_in = PH_DATA; snd_go = 1'b1;
                     end else begin
                        rel_go = 1'b1; rel_stat = full_rd ? ST_ERROR : ST_OK;
                     end
                  end
                  PH_DATA: begin
                     if (off_ff != 10'd0) off_in = off_ff - 10'd1;
                     else if (cnt_ff != 10'd0) begin
                        dat_go = 1'b1; cnt_in = cnt_ff - 10'd1;
                     end else if (bc_ff != 16'd0) bc_in = bc_ff - 16'd1;
                     if (off_in != 10'd0 || cnt_in != 10'd0 || bc_in != 16'd0)
                        snd_go = 1'b1;
                     else rel_go = 1'b1;
                  end
                  PH_RELEASE: begin
                     fin_go = 1'b1;
                     if (is_read_ff) fin_stat = rstat_ff;
                     else begin
                        if (detected_ff != 4'd0) begin
                           init_done_in = 1'b1; high_speed_in = 1'b1;
                        end
                        fin_stat = init_done_in ? ST_OK : ST_NOT_READY;
                     end
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         endcase
      end

      if (cd_go) begin
         if (prefix_ff) begin
            prefix_in = 1'b0;
            if (cd_res > 8'd1) fc_go = 1'b1;
            else beg_go = 1'b1;
         end else fc_go = 1'b1;
      end

      if (fc_go) begin
         case (cmd_ff)
            CMD_GO_IDLE: begin
               if (cd_res == 8'd1) begin
                  long_in = cfg.init_timeout_ticks;
                  st_go = 1'b1; st_cmd = CMD_IF_COND; st_arg = 32'h1AA;
               end else fail_go = 1'b1;
            end
            CMD_IF_COND: begin
               if (cd_res == 8'd1) begin
                  phase_in = PH_OCR; bc_in = 16'd0; snd_go = 1'b1;
               end else begin
                  st_go = 1'b1; st_cmd = ACMD_OP_SD;
               end
            end
            ACMD_OP_SD: begin
               if (arg_ff != 32'd0) begin
                  if (!lt) fail_go = 1'b1;
                  else begin
                     st_go = 1'b1;
                     if (cd_res != 8'd0) begin
                        st_cmd = ACMD_OP_SD; st_arg = 32'h4000_0000;
                     end else st_cmd = CMD_READ_OCR;
                  end
               end else begin
                  if (work_ff == 4'd0) work_in = (cd_res <= 8'd1) ? TYPE_SD1 : TYPE_MMC;
                  if (!lt) fail_go = 1'b1;
                  else begin
                     st_go = 1'b1;
                     if (work_ff == 4'd0 || cd_res != 8'd0)
                        st_cmd = (work_in == TYPE_SD1) ? ACMD_OP_SD : CMD_OP_MMC;
                     else begin
                        st_cmd = CMD_SET_BLEN; st_arg = 32'(SECTOR_BYTES);
                     end
                  end
               end
            end
            CMD_OP_MMC: begin
               if (!lt) fail_go = 1'b1;
               else begin
                  st_go = 1'b1;
                  if (cd_res != 8'd0)
                     st_cmd = (work_ff == TYPE_SD1) ? ACMD_OP_SD : CMD_OP_MMC;
                  else begin
                     st_cmd = CMD_SET_BLEN; st_arg = 32'(SECTOR_BYTES);
                  end
               end
            end
            CMD_READ_OCR: begin
               if (cd_res == 8'd0) begin
                  phase_in = PH_OCR; bc_in = 16'd0; snd_go = 1'b1;
               end else fail_go = 1'b1;
            end
            CMD_SET_BLEN: begin
               if (cd_res != 8'd0) work_in = 4'd0;
               rel_go = 1'b1;
            end
            CMD_READ_ONE: begin
               if (cd_res == 8'd0) begin
                  if (full_rd) long_in = cfg.token_timeout_ticks;
                  else bc_in = cfg.token_wait_polls;
                  phase_in = PH_TOKEN; snd_go = 1'b1;
               end else begin
                  rel_go = 1'b1; rel_stat = ST_ERROR;
               end
            end
            default: begin
               rel_go = 1'b1; rel_stat = ST_ERROR;
            end
         endcase
      end

      if (st_go) begin
         cmd_in = st_cmd; arg_in = st_arg; prefix_in = st_cmd[7]; beg_go = 1'b1;
      end
      if (beg_go) begin
         selected_in = 1'b1; ready_in = cfg.ready_timeout_ticks;
         phase_in = PH_RDY_FIRST; snd_go = 1'b1; snd_byte = IDLE_BYTE;
      end
      if (fail_go) begin
         work_in = 4'd0; rel_go = 1'b1; rel_stat = ST_OK;
      end
      if (rel_go) begin
         selected_in = 1'b0;
         if (!is_read_in) detected_in = work_in;
         rstat_in = rel_stat; phase_in = PH_RELEASE;
         snd_go = 1'b1; snd_byte = IDLE_BYTE;
      end
      if (fin_go) phase_in = PH_IDLE;
   end

   always_comb begin
      div_old = !high_speed_ff ? cfg.slow_divider :
                (detected_ff[0] ? cfg.mmc_fast_divider : cfg.sd_fast_divider);
      div_new = !high_speed_in ? cfg.slow_divider :
                (detected_in[0] ? cfg.mmc_fast_divider : cfg.sd_fast_divider);
      r_data = '{kind: KIND_DATA, tx_byte: 8'd0, chip_select: selected_ff,
                 clock_divider: div_old, data_byte: item.rx_byte, status: ST_OK,
                 card_type: detected_ff, initialized: init_done_ff, last: 1'b0};
      r_main = '{kind: fin_go ? KIND_FINISH : KIND_TX,
                 tx_byte: fin_go ? 8'd0 : snd_byte, chip_select: selected_in,
                 clock_divider: div_new, data_byte: 8'd0,
                 status: fin_go ? fin_stat : ST_OK, card_type: detected_in,
                 initialized: init_done_in, last: fin_go};
      wr.count  = 2'(dat_go) + 2'(snd_go || fin_go);
      wr.first  = dat_go ? r_data : r_main;
      wr.second = r_main;
   end

   always_ff @(posedge clock) begin
      if (go && item.operation == OP_BYTE && phase_ff == PH_OCR) begin
         ocr_ff[bc_ff[1:0]] <= item.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; detected_ff <= 4'd0; work_ff <= 4'd0;
         init_done_ff <= 1'b0; selected_ff <= 1'b0; high_speed_ff <= 1'b0;
         prefix_ff <= 1'b0; is_read_ff <= 1'b0; long_ff <= 16'd0;
         ready_ff <= 16'd0; bc_ff <= 16'd0; polls_ff <= 4'd0; arg_ff <= 32'd0;
         cmd_ff <= 8'd0; off_ff <= 10'd0; cnt_ff <= 10'd0; rstat_ff <= ST_OK;
      end else begin
         phase_ff <= phase_in; detected_ff <= detected_in; work_ff <= work_in;
         init_done_ff <= init_done_in; selected_ff <= selected_in;
         high_speed_ff <= high_speed_in; prefix_ff <= prefix_in;
         is_read_ff <= is_read_in; long_ff <= long_in; ready_ff <= ready_in;
         bc_ff <= bc_in; polls_ff <= polls_in; arg_ff <= arg_in; cmd_ff <= cmd_in;
         off_ff <= off_in; cnt_ff <= cnt_in; rstat_ff <= rstat_in;
      end
   end

`ifndef ASSERT_OFF
   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      (go && fin_go) |=> (phase_ff == PH_IDLE))
      else $error("finish without return to idle");
   a_data_once: assert property (@(posedge clock) disable iff (reset)
      dat_go |-> (phase_ff == PH_DATA && snd_go != fin_go))
      else $error("data byte outside data phase");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      !go |=> $stable(phase_ff))
      else $error("state moved without a transaction");
`endif
endmodule

@@ rtl/core/sd_card_spi_host_sequencer_core.sv @@
`timescale 1ns / 1ps
// channel   ports                               transfer
// request   push, full, req_data                push && !full
// result    pop, empty, rsp_data                pop && !empty
// csr       psel, penable, pwrite, paddr, ...   psel && penable && pwrite
// one transaction is decided when it is taken; while two result slots are free, a new one may enter every cycle
// up to two results per transaction; the sequencer waits for two free result slots
// the request queue holds two transactions, the result queue four
// synchronous active-high reset returns to idle with default register values
module sd_card_spi_host_sequencer_core import sdsh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  req_type     req_data,
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   cfg_type      cfg_ff, cfg_in;
   logic         q_valid, take, room2;
   req_type      q_item;
   rsp_push_type wr;
   logic         csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (paddr[4:2])
            REG_SLOW_DIV:   cfg_in.slow_divider        = pwdata[7:0];
            REG_SD_DIV:     cfg_in.sd_fast_divider     = pwdata[7:0];
            REG_MMC_DIV:    cfg_in.mmc_fast_divider    = pwdata[7:0];
            REG_INIT_TO:    cfg_in.init_timeout_ticks  = pwdata[15:0];
            REG_READY_TO:   cfg_in.ready_timeout_ticks = pwdata[15:0];
            REG_TOKEN_TO:   cfg_in.token_timeout_ticks = pwdata[15:0];
            REG_TOKEN_POLL: cfg_in.token_wait_polls    = pwdata[15:0];
            default: ;
         endcase
      end
      case (paddr[4:2])
         REG_SLOW_DIV:   prdata = 32'(cfg_ff.slow_divider);
         REG_SD_DIV:     prdata = 32'(cfg_ff.sd_fast_divider);
         REG_MMC_DIV:    prdata = 32'(cfg_ff.mmc_fast_divider);
         REG_INIT_TO:    prdata = 32'(cfg_ff.init_timeout_ticks);
         REG_READY_TO:   prdata = 32'(cfg_ff.ready_timeout_ticks);
         REG_TOKEN_TO:   prdata = 32'(cfg_ff.token_timeout_ticks);
         REG_TOKEN_POLL: prdata = 32'(cfg_ff.token_wait_polls);
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{slow_divider: 8'd124, sd_fast_divider: 8'd1,
                     mmc_fast_divider: 8'd2, init_timeout_ticks: 16'd100,
                     ready_timeout_ticks: 16'd50, token_timeout_ticks: 16'd10,
                     token_wait_polls: 16'd40000};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sdsh_req_fifo u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (req_data),
      .full    (full),
      .valid   (q_valid),
      .take    (take),
      .rd_data (q_item)
   );

   sdsh_seq u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (q_valid),
      .item       (q_item),
      .room2      (room2),
      .take       (take),
      .wr         (wr)
   );

   sdsh_rsp_fifo u_out (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .room2   (room2),
      .empty   (empty),
      .pop     (pop),
      .rd_data (rsp_data)
   );
endmodule
